// ----- hdl/ptp_pkg.sv -----
// Package for the periodic timer pool: shared constants, codes and types.
// No dependencies.
`default_nettype none
package ptp_pkg;
    localparam int MaxTimersDefault = 16;
    localparam int TimeW   = 32;
    localparam int HandleW = 31;

    localparam logic [1:0] ModeAdd    = 2'd0;
    localparam logic [1:0] ModeDelete = 2'd1;
    localparam logic [1:0] ModeChange = 2'd2;
    localparam logic [1:0] ModeRun    = 2'd3;

    localparam logic [1:0] StatOk       = 2'd0;
    localparam logic [1:0] StatFull     = 2'd1;
    localparam logic [1:0] StatNotFound = 2'd2;
    localparam logic [1:0] StatIdle     = 2'd3;

    // One timer entry as it travels along the chain.
    typedef struct packed {
        logic [TimeW-1:0]   due;
        logic [TimeW-1:0]   per;
        logic [HandleW-1:0] hdl;
    } entry_t;
endpackage
`default_nettype wire

// ----- hdl/periodic_timer_pool_unit.sv -----
// Top level of the periodic timer pool: a rotating chain of slot cells and
// its sequencer. Depends on ptp_pkg and ptp_cell.
//
// Usage: an item (mode, now_ms, handle, interval_ms) enters on in_valid /
// in_ready; exactly one result item (status, result_handle, fired) leaves on
// out_valid / out_ready. Slots sit in a ring of MAX_TIMERS cells; slot i is
// at cell (i - rot) mod MAX_TIMERS, and the ring rotates one place in each
// cycle that it shifts. Add and run rotate the ring until their slot is at
// cell 0, then write it in S_PUT. Delete and change first bring slot 0
// round, then walk the slots at cell 0 until the handle is found; change
// brings that slot back round, while delete brings the last slot round and
// then the found slot, to move the last entry into it. One item is worked at
// a time; the result waits in an output register, and the next item can be
// taken in the cycle after the result is accepted. After reset the pool is
// empty, the handle counter and cursor are zero; slot contents are undefined
// until written. A stalled receiver simply holds the result and the block
// waits.
`default_nettype none
module periodic_timer_pool_unit #(
    parameter int MAX_TIMERS = ptp_pkg::MaxTimersDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] now_ms,
    input  wire logic [30:0] handle,
    input  wire logic [31:0] interval_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      result_handle,
    output logic             fired
);
    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_TIMERS);

    typedef enum logic [2:0] {S_IDLE, S_SEEK, S_SEARCH, S_TAKE, S_PUT, S_OUT}
        state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [30:0]         next_hdl_reg;
    logic [IW-1:0]       cursor_reg;
    logic [IW-1:0]       rot_reg;
    logic [IW-1:0]       target_reg;
    logic [CW-1:0]       scan_reg;
    logic [1:0]          mode_reg;
    logic [31:0]         now_reg;
    logic [30:0]         hdl_reg;
    logic [31:0]         ival_reg;
    logic                phase_reg;
    ptp_pkg::entry_t     hold_reg;
    logic [1:0]          status_reg;
    logic [31:0]         rhandle_reg;
    logic                fired_reg;

    ptp_pkg::entry_t     cq [MAX_TIMERS];
    logic                shift;
    logic                load0;
    ptp_pkg::entry_t     load_val;
    logic [CW-1:0]       last;
    logic [31:0]         diff;

    // The ring: cell k takes the entry of cell k+1, so slot rot sits at cell 0.
    for (genvar k = 0; k < MAX_TIMERS; k++)
    begin : g_cell
        ptp_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .d     (cq[(k + 1) % MAX_TIMERS]),
            .load  (load0 && k == 0),
            .load_d(load_val),
            .q     (cq[k])
        );
    end

    assign last = count_reg - CW'(1);
    assign diff = now_reg - cq[0].due;

    // Ring control from the sequencer state.
    always_comb
    begin
        shift    = 1'b0;
        load0    = 1'b0;
        load_val = cq[0];
        case (state_reg)
            S_SEEK, S_SEARCH:
            begin
                shift = (rot_reg != target_reg) || (state_reg == S_SEARCH);
            end
            S_TAKE:
            begin
                shift = (rot_reg != target_reg);
            end
            S_PUT:
            begin
                load0 = 1'b1;
                case (mode_reg)
                    ptp_pkg::ModeAdd:
                    begin
                        load_val.due = now_reg + ival_reg;
                        load_val.per = ival_reg;
                        load_val.hdl = next_hdl_reg;
                    end
                    ptp_pkg::ModeDelete:
                    begin
                        load_val = hold_reg;
                    end
                    ptp_pkg::ModeChange:
                    begin
                        load_val.due = now_reg + ival_reg;
                        load_val.per = ival_reg;
                    end
                    default:
                    begin
                        load0 = ~diff[31];
                        load_val.due = now_reg + cq[0].per;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer: one item at a time, result held until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            next_hdl_reg <= '0;
            cursor_reg   <= '0;
            rot_reg      <= '0;
            target_reg   <= '0;
            scan_reg     <= '0;
            phase_reg    <= 1'b0;
            mode_reg     <= '0;
            now_reg      <= '0;
            hdl_reg      <= '0;
            ival_reg     <= '0;
            hold_reg     <= '0;
            status_reg   <= '0;
            rhandle_reg  <= '0;
            fired_reg    <= 1'b0;
        end
        else
        begin
            if (shift)
            begin
                rot_reg <= (rot_reg == IW'(MAX_TIMERS - 1)) ? '0 : rot_reg + IW'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg    <= mode;
                        now_reg     <= now_ms;
                        hdl_reg     <= handle;
                        ival_reg    <= interval_ms;
                        fired_reg   <= 1'b0;
                        rhandle_reg <= '1;
                        phase_reg   <= 1'b0;
                        scan_reg    <= '0;
                        case (mode)
                            ptp_pkg::ModeAdd:
                            begin
                                if (count_reg == CMAX)
                                begin
                                    status_reg <= ptp_pkg::StatFull;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    target_reg <= count_reg[IW-1:0];
                                    state_reg  <= S_SEEK;
                                end
                            end
                            ptp_pkg::ModeRun:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ptp_pkg::StatIdle;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    target_reg <= cursor_reg;
                                    state_reg  <= S_SEEK;
                                end
                            end
                            default:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ptp_pkg::StatNotFound;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    target_reg <= '0;
                                    state_reg  <= S_TAKE;
                                end
                            end
                        endcase
                    end
                end
                S_SEEK:
                begin
                    if (rot_reg == target_reg)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_TAKE:
                begin
                    // Bring slot 0 round to search, or the last slot to hold.
                    if (rot_reg == target_reg)
                    begin
                        if (phase_reg)
                        begin
                            hold_reg   <= cq[0];
                            phase_reg  <= 1'b0;
                            state_reg  <= S_SEEK;
                            target_reg <= scan_reg[IW-1:0];
                        end
                        else
                        begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (cq[0].hdl == hdl_reg)
                    begin
                        // Found at slot scan_reg; cell 0 holds it now.
                        if (mode_reg == ptp_pkg::ModeDelete)
                        begin
                            target_reg <= last[IW-1:0];
                            phase_reg  <= 1'b1;
                            state_reg  <= S_TAKE;
                        end
                        else
                        begin
                            target_reg <= scan_reg[IW-1:0];
                            state_reg  <= S_SEEK;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CW'(1);
                        if (scan_reg == last)
                        begin
                            status_reg <= ptp_pkg::StatNotFound;
                            state_reg  <= S_OUT;
                        end
                    end
                end
                S_PUT:
                begin
                    status_reg <= ptp_pkg::StatOk;
                    state_reg  <= S_OUT;
                    case (mode_reg)
                        ptp_pkg::ModeAdd:
                        begin
                            rhandle_reg  <= {1'b0, next_hdl_reg};
                            count_reg    <= count_reg + CW'(1);
                            next_hdl_reg <= next_hdl_reg + 31'd1;
                        end
                        ptp_pkg::ModeDelete:
                        begin
                            count_reg <= last;
                            if (CW'(cursor_reg) >= last)
                            begin
                                cursor_reg <= '0;
                            end
                        end
                        ptp_pkg::ModeChange:
                        begin
                        end
                        default:
                        begin
                            cursor_reg <= (CW'(cursor_reg) + CW'(1) >= count_reg)
                                ? '0 : cursor_reg + IW'(1);
                            if (!diff[31])
                            begin
                                fired_reg   <= 1'b1;
                                rhandle_reg <= {1'b0, cq[0].hdl};
                            end
                            else
                            begin
                                status_reg <= ptp_pkg::StatIdle;
                            end
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign status        = status_reg;
    assign result_handle = rhandle_reg;
    assign fired         = fired_reg;
endmodule
`default_nettype wire

// ----- hdl/ptp_cell.sv -----
// One slot of the timer chain: holds an entry and passes it on while the
// chain rotates by one place each shift cycle. Depends on ptp_pkg.
`default_nettype none
module ptp_cell (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire ptp_pkg::entry_t d,
    input  wire logic            load,
    input  wire ptp_pkg::entry_t load_d,
    output ptp_pkg::entry_t      q
);
    ptp_pkg::entry_t q_reg;

    // Entry register: loads a new value or takes the neighbour's entry.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= load_d;
        end
        else if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire
